FILE: hdl/ddc_pkg.sv
// Package for the distance dip counter: word types, field widths,
// register reset values and register index codes. No dependencies.
package ddc_pkg;

	localparam int DATA_W    = 24;
	localparam int COUNT_W   = 7;
	localparam int SPACING_W = 7;
	localparam int CFG_IDX_W = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

	localparam logic [DATA_W-1:0]    DIP_LIMIT_RST   = 24'd384;
	localparam logic [DATA_W-1:0]    RISE_LIMIT_RST  = 24'd1280;
	localparam logic [DATA_W-1:0]    FLOOR_LIMIT_RST = 24'd256;
	localparam logic [SPACING_W-1:0] MIN_SPACING_RST = 7'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_DIP_LIMIT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RISE_LIMIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_LIMIT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPACING = 2'd3;

	typedef struct packed {
		logic [DATA_W-1:0] distance;
		logic              last;
	} in_word_t;

	typedef struct packed {
		logic [COUNT_W-1:0] dip_count;
		logic               odd;
		logic               overflow;
	} out_word_t;

endpackage

FILE: hdl/distance_dip_counter.sv
// Distance dip counter top level: counts dips in a run of squared-distance
// samples and reports the count on the last sample. Depends on ddc_pkg.
//
//   channel  direction  handshake                   word
//   in       sink       in_valid / in_stall          ddc_pkg::in_word_t
//   out      source     out_valid / out_stall        ddc_pkg::out_word_t
//   cfg      sink       cfg_we, cfg_index, cfg_data  24-bit register data
//
// One sample per cycle while in_stall is low; after its last sample is accepted,
// a result passes through the input register, then the result register, and
// is held there until out_stall is low.
// The run state updates from the input register in a single pass.
// Reset restores the register defaults and clears the run state.
// A last sample waits in the input register while a previous result is
// held by out_stall; other samples flow on.
module distance_dip_counter #(
	parameter int LAG         = 4,
	parameter int MAX_SAMPLES = 128
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  ddc_pkg::in_word_t                    in_word,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output ddc_pkg::out_word_t                   out_word,
	input  logic                                 cfg_we,
	input  logic [ddc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ddc_pkg::DATA_W-1:0]           cfg_data
);

	localparam int WIN = 2 * LAG;
	localparam int PW  = $clog2(MAX_SAMPLES + 1);
	localparam int IW  = $clog2(MAX_SAMPLES);
	localparam int SW  = (IW > ddc_pkg::SPACING_W) ? IW : ddc_pkg::SPACING_W;
	localparam int DW  = ddc_pkg::DATA_W;
	localparam int CW  = ddc_pkg::COUNT_W;

	logic [DW-1:0]                  dip_limit_q;
	logic [DW-1:0]                  rise_limit_q;
	logic [DW-1:0]                  floor_limit_q;
	logic [ddc_pkg::SPACING_W-1:0]  min_spacing_q;

	logic                           valid_s1;
	ddc_pkg::in_word_t              word_s1;

	logic [DW-1:0]                  win_q [WIN];
	logic [PW-1:0]                  pos_q;
	logic [IW-1:0]                  last_dip_q;
	logic [CW-1:0]                  count_q;
	logic [DW-1:0]                  min_q;
	logic [IW-1:0]                  min_pos_q;
	logic                           overflowed_q;

	logic                           out_valid_q;
	ddc_pkg::out_word_t             out_word_q;

	logic                           blocked;
	logic                           adv;
	logic                           ovf_hit;
	logic                           take_min;
	logic                           test;
	logic                           dip;
	logic [DW-1:0]                  d;
	logic [DW-1:0]                  centre;
	logic [DW-1:0]                  left;
	logic [PW-1:0]                  ci_full;
	logic [IW-1:0]                  ci;
	logic [IW-1:0]                  gap;
	logic [DW-1:0]                  min_n;
	logic [IW-1:0]                  min_pos_n;
	logic [CW-1:0]                  count_n;
	logic [CW-1:0]                  result;
	logic                           ovf_n;

	assign blocked   = valid_s1 && word_s1.last && out_valid_q && out_stall;
	assign adv       = valid_s1 && !blocked;
	assign in_stall  = blocked;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	always_comb begin
		d         = word_s1.distance;
		centre    = win_q[LAG-1];
		left      = win_q[WIN-1];
		ovf_hit   = pos_q >= PW'(MAX_SAMPLES);
		take_min  = !ovf_hit && ((pos_q == '0) || (d < min_q));
		min_n     = take_min ? d : min_q;
		min_pos_n = take_min ? pos_q[IW-1:0] : min_pos_q;
		test      = !ovf_hit && ({{(32-PW){1'b0}}, pos_q} >= 32'(WIN));
		ci_full   = pos_q - PW'(LAG);
		ci        = ci_full[IW-1:0];
		gap       = ci - last_dip_q;
		dip       = test && (centre < dip_limit_q)
			&& (left > centre) && (d > centre)
			&& ((left - centre) > rise_limit_q)
			&& ((d - centre) > rise_limit_q)
			&& (ci >= last_dip_q)
			&& (SW'(gap) >= SW'(min_spacing_q));
		count_n   = (dip && (count_q != ddc_pkg::COUNT_MAX)) ? count_q + 1'b1 : count_q;
		ovf_n     = overflowed_q | ovf_hit;
		result    = ((count_n == '0) && (min_n < floor_limit_q) && (min_pos_n != '0))
			? CW'(1) : count_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dip_limit_q   <= ddc_pkg::DIP_LIMIT_RST;
			rise_limit_q  <= ddc_pkg::RISE_LIMIT_RST;
			floor_limit_q <= ddc_pkg::FLOOR_LIMIT_RST;
			min_spacing_q <= ddc_pkg::MIN_SPACING_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ddc_pkg::CFG_DIP_LIMIT:   dip_limit_q   <= cfg_data;
				ddc_pkg::CFG_RISE_LIMIT:  rise_limit_q  <= cfg_data;
				ddc_pkg::CFG_FLOOR_LIMIT: floor_limit_q <= cfg_data;
				ddc_pkg::CFG_MIN_SPACING: min_spacing_q <= cfg_data[ddc_pkg::SPACING_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			word_s1 <= in_word;
		end
	end

	// sample window, filled anew each run before any centre is tested
	always_ff @(posedge clk) begin
		if (adv && !ovf_hit) begin
			win_q[0] <= d;
			for (int k = 1; k < WIN; k++) begin
				win_q[k] <= win_q[k-1];
			end
		end
	end

	// run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			last_dip_q   <= '0;
			count_q      <= '0;
			min_q        <= '1;
			min_pos_q    <= '0;
			overflowed_q <= 1'b0;
		end else if (adv) begin
			if (word_s1.last) begin
				pos_q        <= '0;
				last_dip_q   <= '0;
				count_q      <= '0;
				min_q        <= '1;
				min_pos_q    <= '0;
				overflowed_q <= 1'b0;
			end else begin
				pos_q        <= ovf_hit ? pos_q : pos_q + 1'b1;
				last_dip_q   <= dip ? ci : last_dip_q;
				count_q      <= count_n;
				min_q        <= min_n;
				min_pos_q    <= min_pos_n;
				overflowed_q <= ovf_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && word_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && word_s1.last) begin
			out_word_q.dip_count <= result;
			out_word_q.odd       <= result[0];
			out_word_q.overflow  <= ovf_n;
		end
	end

endmodule

FILE: verif/tb_distance_dip_counter.sv
// Testbench for distance_dip_counter: random and directed runs of distance
// samples, checked word by word against an in-bench dip predictor.
// Depends on ddc_pkg and the distance_dip_counter RTL.
module tb_distance_dip_counter;

	localparam int LAG         = 4;
	localparam int MAX_SAMPLES = 128;
	localparam int WIN_LEN     = 2 * LAG + 1;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 120;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           in_valid  = 1'b0;
	logic                           in_stall;
	ddc_pkg::in_word_t              in_word   = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	ddc_pkg::out_word_t             out_word;
	logic                           cfg_we    = 1'b0;
	logic [ddc_pkg::CFG_IDX_W-1:0]  cfg_index = ddc_pkg::CFG_DIP_LIMIT;
	logic [ddc_pkg::DATA_W-1:0]     cfg_data  = '0;

	distance_dip_counter #(
		.LAG         (LAG),
		.MAX_SAMPLES (MAX_SAMPLES)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// register copies
	logic [ddc_pkg::DATA_W-1:0]    dip_lim   = ddc_pkg::DIP_LIMIT_RST;
	logic [ddc_pkg::DATA_W-1:0]    rise_lim  = ddc_pkg::RISE_LIMIT_RST;
	logic [ddc_pkg::DATA_W-1:0]    floor_lim = ddc_pkg::FLOOR_LIMIT_RST;
	logic [ddc_pkg::SPACING_W-1:0] spacing   = ddc_pkg::MIN_SPACING_RST;

	// run state of the predictor
	logic [ddc_pkg::DATA_W-1:0]    dist_window [WIN_LEN];
	logic [7:0]                    sample_pos   = '0;
	logic [ddc_pkg::COUNT_W-1:0]   last_dip_pos = '0;
	logic [ddc_pkg::COUNT_W-1:0]   dips_found   = '0;
	logic [ddc_pkg::DATA_W-1:0]    min_dist     = '1;
	logic [ddc_pkg::COUNT_W-1:0]   min_pos      = '0;
	logic                          run_overflow = 1'b0;

	ddc_pkg::in_word_t             pending_samples [$];
	ddc_pkg::out_word_t            expected_counts [$];

	int  samples_queued, samples_taken, runs_queued;
	int  counts_checked, nonzero_counts, overflow_counts, mismatches;
	int  hold_requests, hold_served, hold_left, stall_left, send_gap;
	int  cycles, settings_used;
	bit  quiet;

	initial begin
		for (int k = 0; k < WIN_LEN; k++)
			dist_window[k] = '0;
	end

	function automatic int pick_gap();
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [ddc_pkg::DATA_W-1:0] pick_distance();
		int unsigned r;
		longint      v;
		r = $urandom_range(0, 99);
		if (r < 28)
			v = (dip_lim == 0) ? 0 : $urandom_range(0, dip_lim - 1);
		else if (r < 68)
			v = longint'(dip_lim) + longint'(rise_lim) + $urandom_range(1, 4000);
		else if (r < 76)
			v = longint'(rise_lim) + $urandom_range(0, 1);
		else if (r < 82)
			v = longint'(dip_lim) - $urandom_range(0, 1);
		else if (r < 90)
			v = $urandom_range(0, 1) ? 24'hFFFFFF : 0;
		else
			v = $urandom_range(0, 24'hFFFFFF);
		if (v < 0)
			v = 0;
		if (v > 24'hFFFFFF)
			v = 24'hFFFFFF;
		return v[ddc_pkg::DATA_W-1:0];
	endfunction

	task automatic count_dip_sample(ddc_pkg::in_word_t w);
		logic [ddc_pkg::DATA_W-1:0]  centre, left_s, right_s;
		logic [ddc_pkg::COUNT_W-1:0] total;
		ddc_pkg::out_word_t          res;
		int                          centre_pos, k;
		if (sample_pos >= MAX_SAMPLES) begin
			run_overflow = 1'b1;
		end else begin
			for (k = WIN_LEN - 1; k > 0; k--)
				dist_window[k] = dist_window[k - 1];
			dist_window[0] = w.distance;
			if (sample_pos == 0 || w.distance < min_dist) begin
				min_dist = w.distance;
				min_pos  = sample_pos[ddc_pkg::COUNT_W-1:0];
			end
			if (sample_pos >= 2 * LAG) begin
				right_s    = dist_window[0];
				centre     = dist_window[LAG];
				left_s     = dist_window[2 * LAG];
				centre_pos = int'(sample_pos) - LAG;
				if (centre < dip_lim && left_s > centre && right_s > centre
						&& (left_s - centre) > rise_lim && (right_s - centre) > rise_lim
						&& centre_pos >= int'(last_dip_pos)
						&& (centre_pos - int'(last_dip_pos)) >= int'(spacing)) begin
					if (dips_found != ddc_pkg::COUNT_MAX)
						dips_found++;
					last_dip_pos = centre_pos[ddc_pkg::COUNT_W-1:0];
				end
			end
			sample_pos++;
		end
		if (w.last) begin
			total = dips_found;
			if (total == 0 && min_dist < floor_lim && min_pos != 0)
				total = 1;
			res.dip_count = total;
			res.odd       = total[0];
			res.overflow  = run_overflow;
			expected_counts.insert(expected_counts.size(), res);
			for (k = 0; k < WIN_LEN; k++)
				dist_window[k] = '0;
			sample_pos   = '0;
			last_dip_pos = '0;
			dips_found   = '0;
			min_dist     = '1;
			min_pos      = '0;
			run_overflow = 1'b0;
		end
	endtask

	// driver: hold a stalled word, advance on acceptance
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid) begin
				count_dip_sample(in_word);
				samples_taken++;
				send_gap = pick_gap();
			end
			if (send_gap > 0 || pending_samples.size() == 0) begin
				if (send_gap > 0)
					send_gap--;
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				in_word  <= pending_samples.pop_front();
			end
		end
	end

	// monitor: check each accepted result word, drive out_stall
	always @(posedge clk) begin
		ddc_pkg::out_word_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_counts.size() == 0) begin
					$error("result word with no count pending: dip_count %0d odd %0d overflow %0d",
						out_word.dip_count, out_word.odd, out_word.overflow);
					mismatches++;
				end else begin
					want = expected_counts.pop_front();
					if (out_word.dip_count !== want.dip_count) begin
						$error("dip_count: expected %0d, got %0d", want.dip_count, out_word.dip_count);
						mismatches++;
					end
					if (out_word.odd !== want.odd) begin
						$error("odd: expected %0d, got %0d", want.odd, out_word.odd);
						mismatches++;
					end
					if (out_word.overflow !== want.overflow) begin
						$error("overflow: expected %0d, got %0d", want.overflow, out_word.overflow);
						mismatches++;
					end
					counts_checked++;
					if (want.dip_count != 0)
						nonzero_counts++;
					if (want.overflow)
						overflow_counts++;
				end
			end
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_distance_dip_counter: done, errors");
			$finish;
		end
	end

	task automatic write_reg(logic [ddc_pkg::CFG_IDX_W-1:0] idx,
			logic [ddc_pkg::DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			ddc_pkg::CFG_DIP_LIMIT:   dip_lim   = val;
			ddc_pkg::CFG_RISE_LIMIT:  rise_lim  = val;
			ddc_pkg::CFG_FLOOR_LIMIT: floor_lim = val;
			ddc_pkg::CFG_MIN_SPACING: spacing   = val[ddc_pkg::SPACING_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_limits(logic [ddc_pkg::DATA_W-1:0] dip,
			logic [ddc_pkg::DATA_W-1:0] rise,
			logic [ddc_pkg::DATA_W-1:0] floor_v, logic [ddc_pkg::SPACING_W-1:0] gap_v);
		write_reg(ddc_pkg::CFG_DIP_LIMIT, dip);
		write_reg(ddc_pkg::CFG_RISE_LIMIT, rise);
		write_reg(ddc_pkg::CFG_FLOOR_LIMIT, floor_v);
		write_reg(ddc_pkg::CFG_MIN_SPACING, ddc_pkg::DATA_W'(gap_v));
		settings_used++;
	endtask

	task automatic queue_sample(logic [ddc_pkg::DATA_W-1:0] d, logic is_last);
		ddc_pkg::in_word_t w;
		w.distance = d;
		w.last     = is_last;
		pending_samples.insert(pending_samples.size(), w);
		samples_queued++;
		if (is_last)
			runs_queued++;
	endtask

	task automatic queue_run(int len, bit noisy);
		int i;
		for (i = 0; i < len; i++)
			queue_sample(noisy ? ddc_pkg::DATA_W'($urandom_range(0, 24'hFFFFFF))
				: pick_distance(), i == len - 1);
	endtask

	// wait for every word to pass, then for the pipeline to settle
	task automatic drain();
		while (samples_taken != samples_queued || expected_counts.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int p, i, r, len, phase_items;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		set_limits(ddc_pkg::DIP_LIMIT_RST, ddc_pkg::RISE_LIMIT_RST,
			ddc_pkg::FLOOR_LIMIT_RST, ddc_pkg::MIN_SPACING_RST);
		// one dip at position five
		for (i = 0; i < 11; i++)
			queue_sample((i == 5) ? 24'd100 : 24'd3000, i == 10);
		// short run, fallback from a low minimum past position zero
		queue_sample(24'hFFFFFF, 1'b0);
		queue_sample(24'd0, 1'b0);
		queue_sample(24'd200, 1'b1);
		// minimum at position zero
		queue_sample(24'd0, 1'b1);
		// equal minima keep the first position
		queue_sample(24'd10, 1'b0);
		queue_sample(24'd10, 1'b1);
		drain();

		for (p = 0; p < PHASES; p++) begin
			quiet = (p == 5 || p == 9);
			case (p)
				0: set_limits(ddc_pkg::DIP_LIMIT_RST, ddc_pkg::RISE_LIMIT_RST,
					ddc_pkg::FLOOR_LIMIT_RST, ddc_pkg::MIN_SPACING_RST);
				1: set_limits(24'hFFFFFF, 24'd0, 24'hFFFFFF, 7'd0);
				2: set_limits(24'd0, 24'hFFFFFF, 24'd0, 7'd127);
				3: set_limits(24'hFFFFFF, 24'hFFFFFF, 24'd0, 7'd1);
				default: begin
					if ($urandom_range(0, 3) == 0)
						set_limits(ddc_pkg::DATA_W'($urandom_range(0, 24'hFFFFFF)),
							ddc_pkg::DATA_W'($urandom_range(0, 24'hFFFFFF)),
							ddc_pkg::DATA_W'($urandom_range(0, 24'hFFFFFF)),
							ddc_pkg::SPACING_W'($urandom_range(0, 127)));
					else
						set_limits(ddc_pkg::DATA_W'($urandom_range(1, 5000)),
							ddc_pkg::DATA_W'($urandom_range(0, 8000)),
							ddc_pkg::DATA_W'($urandom_range(0, 3000)),
							ddc_pkg::SPACING_W'($urandom_range(0, 12)));
				end
			endcase
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 8)
					len = $urandom_range(MAX_SAMPLES - 3, MAX_SAMPLES + 7);
				else if (r < 22)
					len = $urandom_range(1, 2 * LAG);
				else
					len = $urandom_range(2 * LAG + 1, 40);
				queue_run(len, $urandom_range(0, 99) < 15);
				phase_items += len;
			end
			drain();
			if (p == 3) begin
				// stall the result side long enough to back up the input
				hold_requests++;
				for (i = 0; i < 40; i++)
					queue_run($urandom_range(1, 3), 1'b0);
				drain();
			end
		end
		quiet = 1'b0;

		drain();
		repeat (10) @(posedge clk);
		$display("covered %0d samples in %0d runs over %0d register settings",
			samples_taken, runs_queued, settings_used);
		$display("%0d counts checked, %0d nonzero, %0d with overflow",
			counts_checked, nonzero_counts, overflow_counts);
		if (mismatches == 0 && expected_counts.size() == 0) begin
			$display("tb_distance_dip_counter: done, clean");
		end else begin
			$display("tb_distance_dip_counter: done, errors");
		end
		$finish;
	end

endmodule
